/* hw/rtl/spd_pkg.sv */
package spd_pkg;

  // field and datapath widths
  localparam int RPM_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int ERR_W     = 17;
  localparam int DLT_W     = 18;
  localparam int SUM_W     = 32;
  localparam int ACC_W     = 50;
  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 16;
  localparam int DUTY_W    = 8;
  localparam int CFG_IDX_W = 3;

  // full-scale duty
  localparam int DUTY_FULL = 255;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RPM    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RPM       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RPM       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KP            = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_KI            = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_KD            = 3'd7;

  typedef struct packed {
    logic             run;
    logic [RPM_W-1:0] measured_rpm;
  } in_item_t;

  typedef struct packed {
    logic              duty_valid;
    logic [DUTY_W-1:0] duty;
    logic [RPM_W-1:0]  commanded_rpm;
  } out_item_t;

  // command to the serial multiplier
  typedef struct packed {
    logic start;
    logic clear;
  } mac_cmd_t;

endpackage

/* hw/rtl/spd_serial_mac.sv */
// Shift-add multiply-accumulate, one gain bit per cycle, LSB first.
module spd_serial_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  spd_pkg::mac_cmd_t                  cmd,
  input  logic signed [spd_pkg::SUM_W-1:0]   operand,
  input  logic [spd_pkg::GAIN_W-1:0]         gain,
  output logic                               done,
  output logic signed [spd_pkg::ACC_W-1:0]   acc
);
  import spd_pkg::*;

  localparam int CNT_W = $clog2(GAIN_W);

  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  logic signed [ACC_W-1:0] opnd;
  logic [GAIN_W-1:0]       gain_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(GAIN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      opnd    <= {{(ACC_W-SUM_W){operand[SUM_W-1]}}, operand};
      gain_sh <= gain;
      if (cmd.clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (gain_sh[0]) begin
        acc <= acc + opnd;
      end
      opnd    <= opnd <<< 1;
      gain_sh <= gain_sh >> 1;
    end
  end

endmodule

/* hw/rtl/spd_serial_div.sv */
// Restoring divider, one quotient bit per cycle.
module spd_serial_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [spd_pkg::DIV_NUM_W-1:0]    num,
  input  logic [spd_pkg::DIV_DEN_W-1:0]    den,
  output logic                             done,
  output logic [spd_pkg::DIV_NUM_W-1:0]    quot
);
  import spd_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  // quotient bits shift in behind the numerator
  assign trial = {rem, quot[DIV_NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      den_q <= den;
      rem   <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= DIV_DEN_W'(trial - {1'b0, den_q});
      end else begin
        rem <= trial[DIV_DEN_W-1:0];
      end
      quot <= {quot[DIV_NUM_W-2:0], fits};
    end
  end

endmodule

/* hw/rtl/sampled_pid_speed_to_duty_top.sv */
// Sampled PID speed controller. Each input transfer is one 1 ms tick with a
// run flag and the measured speed; each tick yields exactly one output
// transfer. A low run flag (or any register write) returns the controller to
// its init phase and clears the tick count; the integral and last-error state
// are kept. With mode 0 the controller enters protect and runs a PID step
// once the tick count exceeds sample_period; that result carries
// duty_valid = 1, the clamped rpm and duty = rpm * 255 / max_rpm (saturated,
// 0 when max_rpm is 0). All other ticks give an all-zero result.
// Sequence: a tick without a PID step goes from idle straight to the output
// state. A PID step runs the serial divider for the integral limit
// max_rpm*256/ki, three passes of the shift-add multiplier (kp, ki, kd
// terms), a clamp state, a second divider pass for the duty scaling and the
// output state, which moves the result to the output register. One tick is
// processed at a time; the next input transfer is taken once the result has
// moved to the output register, even if the sink has not taken it yet. A
// stalled sink holds the block in its output state.
module sampled_pid_speed_to_duty_top (
  input  logic                             clk,
  input  logic                             rst,
  // tick input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  spd_pkg::in_item_t                in_data,
  // result output
  output logic                             out_valid,
  input  logic                             out_ready,
  output spd_pkg::out_item_t               out_data,
  // register write port
  input  logic                             cfg_write,
  input  logic [spd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spd_pkg::RPM_W-1:0]        cfg_data
);
  import spd_pkg::*;

  typedef enum logic [1:0] {
    PH_INIT    = 2'd0,
    PH_PROTECT = 2'd1,
    PH_RELEASE = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIM,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_CLAMP,
    S_DUTY,
    S_EMIT
  } state_t;

  localparam int R_W = ACC_W - 8;

  // configuration registers
  logic              mode;
  logic [RPM_W-1:0]  sample_period;
  logic [RPM_W-1:0]  target_rpm;
  logic [RPM_W-1:0]  max_rpm;
  logic [RPM_W-1:0]  min_rpm;
  logic [GAIN_W-1:0] kp;
  logic [GAIN_W-1:0] ki;
  logic [GAIN_W-1:0] kd;

  // controller state
  state_t            state;
  phase_t            phase;
  logic [RPM_W-1:0]  tick_count;
  logic signed [SUM_W-1:0] error_sum;
  logic signed [ERR_W-1:0] last_error;

  // working registers of one step
  logic signed [ERR_W-1:0] err;
  logic signed [SUM_W-1:0] psum;
  logic signed [DLT_W-1:0] dlt;
  logic [RPM_W-1:0]        rpm;
  out_item_t               res;

  // unit controls
  mac_cmd_t                mac_cmd;
  logic signed [SUM_W-1:0] mac_opnd;
  logic [GAIN_W-1:0]       mac_gain;
  logic                    mac_done;
  logic signed [ACC_W-1:0] mac_acc;
  logic                    div_start;
  logic [DIV_NUM_W-1:0]    div_num;
  logic [DIV_DEN_W-1:0]    div_den;
  logic                    div_done;
  logic [DIV_NUM_W-1:0]    div_quot;

  // combinational helpers
  logic [RPM_W-1:0]        tick_inc;
  logic signed [ERR_W-1:0] err_in;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;
  logic signed [SUM_W-1:0] sum_lim;
  logic signed [R_W-1:0]   r_val;
  logic [RPM_W-1:0]        rpm_clamp;

  assign in_ready = (state == S_IDLE);

  assign tick_inc = (tick_count == '1) ? tick_count : tick_count + 1'b1;
  assign err_in   = $signed({1'b0, target_rpm}) - $signed({1'b0, in_data.measured_rpm});

  // saturating integral update
  assign sum_wide = {error_sum[SUM_W-1], error_sum}
                  + {{(SUM_W+1-ERR_W){err_in[ERR_W-1]}}, err_in};
  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  // upper clamp of the integral at max_rpm*256/ki
  always_comb begin
    sum_lim = psum;
    if ((ki != '0) && (psum > $signed({{(SUM_W-DIV_NUM_W){1'b0}}, div_quot}))) begin
      sum_lim = $signed({{(SUM_W-DIV_NUM_W){1'b0}}, div_quot});
    end
  end

  // floor(acc / 256), then output clamp
  assign r_val = mac_acc[ACC_W-1:8];
  always_comb begin
    if (r_val > $signed({{(R_W-RPM_W){1'b0}}, max_rpm})) begin
      rpm_clamp = max_rpm;
    end else if (r_val < $signed({{(R_W-RPM_W){1'b0}}, min_rpm})) begin
      rpm_clamp = min_rpm;
    end else begin
      rpm_clamp = r_val[RPM_W-1:0];
    end
  end

  spd_serial_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .cmd     (mac_cmd),
    .operand (mac_opnd),
    .gain    (mac_gain),
    .done    (mac_done),
    .acc     (mac_acc)
  );

  spd_serial_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= 1'b0;
      sample_period <= 16'd10;
      target_rpm    <= '0;
      max_rpm       <= 16'd3000;
      min_rpm       <= '0;
      kp            <= 16'd256;
      ki            <= '0;
      kd            <= '0;
      state         <= S_IDLE;
      phase         <= PH_INIT;
      tick_count    <= '0;
      error_sum     <= '0;
      last_error    <= '0;
      out_valid     <= 1'b0;
      mac_cmd       <= '0;
      div_start     <= 1'b0;
    end else begin
      mac_cmd   <= '0;
      div_start <= 1'b0;

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // register writes must only arrive while idle; not enforced by the block
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_MODE:          mode          <= cfg_data[0];
          CFG_SAMPLE_PERIOD: sample_period <= cfg_data;
          CFG_TARGET_RPM:    target_rpm    <= cfg_data;
          CFG_MAX_RPM:       max_rpm       <= cfg_data;
          CFG_MIN_RPM:       min_rpm       <= cfg_data;
          CFG_KP:            kp            <= cfg_data;
          CFG_KI:            ki            <= cfg_data;
          CFG_KD:            kd            <= cfg_data;
        endcase
        phase      <= PH_INIT;
        tick_count <= '0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            res   <= '0;
            state <= S_EMIT;
            if (!in_data.run) begin
              phase      <= PH_INIT;
              tick_count <= '0;
            end else begin
              case (phase)
                PH_INIT: begin
                  phase      <= mode ? PH_RELEASE : PH_PROTECT;
                  tick_count <= '0;
                end
                PH_PROTECT: begin
                  if (tick_inc > sample_period) begin
                    tick_count <= '0;
                    err        <= err_in;
                    psum       <= sum_sat;
                    div_num    <= {max_rpm, 8'd0};
                    div_den    <= ki;
                    div_start  <= 1'b1;
                    state      <= S_LIM;
                  end else begin
                    tick_count <= tick_inc;
                  end
                end
                PH_RELEASE: tick_count <= tick_inc;
                default:    tick_count <= tick_inc;
              endcase
            end
          end
        end

        S_LIM: begin
          if (div_done) begin
            error_sum  <= sum_lim;
            last_error <= err;
            dlt        <= DLT_W'(err) - DLT_W'(last_error);
            mac_opnd   <= SUM_W'(err);
            mac_gain   <= kp;
            mac_cmd    <= '{start: 1'b1, clear: 1'b1};
            state      <= S_MUL_P;
          end
        end

        S_MUL_P: begin
          if (mac_done) begin
            mac_opnd <= error_sum;
            mac_gain <= ki;
            mac_cmd  <= '{start: 1'b1, clear: 1'b0};
            state    <= S_MUL_I;
          end
        end

        S_MUL_I: begin
          if (mac_done) begin
            mac_opnd <= SUM_W'(dlt);
            mac_gain <= kd;
            mac_cmd  <= '{start: 1'b1, clear: 1'b0};
            state    <= S_MUL_D;
          end
        end

        S_MUL_D: begin
          if (mac_done) begin
            state <= S_CLAMP;
          end
        end

        S_CLAMP: begin
          rpm       <= rpm_clamp;
          div_num   <= DIV_NUM_W'(rpm_clamp * DIV_NUM_W'(DUTY_FULL));
          div_den   <= max_rpm;
          div_start <= 1'b1;
          state     <= S_DUTY;
        end

        S_DUTY: begin
          if (div_done) begin
            res.duty_valid    <= 1'b1;
            res.commanded_rpm <= rpm;
            if (max_rpm == '0) begin
              res.duty <= '0;
            end else if (div_quot > DIV_NUM_W'(255)) begin
              res.duty <= '1;
            end else begin
              res.duty <= div_quot[DUTY_W-1:0];
            end
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/sv/sampled_pid_speed_to_duty_checker.sv */
`timescale 1ns / 1ps

module sampled_pid_speed_to_duty_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  spd_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  spd_pkg::out_item_t            out_data,
  input  logic                          cfg_write,
  input  logic [spd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spd_pkg::RPM_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            pending
);

  import spd_pkg::*;

  typedef enum logic [1:0] {
    PHASE_INIT    = 2'd0,
    PHASE_PROTECT = 2'd1,
    PHASE_RELEASE = 2'd2
  } phase_e;

  localparam longint SUM_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam longint TICK_MAX = 65535;

  // register mirror
  logic   mode_rel;
  longint period, target, rpm_max, rpm_min, gain_p, gain_i, gain_d;

  // controller state
  phase_e phase;
  longint ticks;
  longint err_sum;
  longint prev_err;

  out_item_t duty_expected_q[$];

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // one PID step; updates the integral and last error, returns clamped rpm
  function automatic logic [15:0] pid_rpm(input logic [15:0] meas);
    longint e, s, lim, acc, r;
    e = target - longint'(meas);
    s = err_sum + e;
    if (s > SUM_MAX) s = SUM_MAX;
    if (s < SUM_MIN) s = SUM_MIN;
    if (gain_i != 0) begin
      lim = (rpm_max * 256) / gain_i;
      if (s > lim) s = lim;
    end
    err_sum = s;
    acc = gain_p * e + gain_i * s + gain_d * (e - prev_err);
    r = acc >>> 8;
    if (r > rpm_max) r = rpm_max;
    else if (r < rpm_min) r = rpm_min;
    prev_err = e;
    return r[15:0];
  endfunction

  function automatic logic [7:0] duty_of(input logic [15:0] rpm);
    longint d;
    if (rpm_max == 0) return 8'd0;
    d = rpm;
    d = (d * DUTY_FULL) / rpm_max;
    return (d > 255) ? 8'd255 : d[7:0];
  endfunction

  function automatic out_item_t advance_tick(input in_item_t t);
    out_item_t res;
    res = '0;
    if (!t.run) begin
      phase = PHASE_INIT;
      ticks = 0;
    end else begin
      if (ticks < TICK_MAX) ticks++;
      case (phase)
        PHASE_INIT: begin
          phase = mode_rel ? PHASE_RELEASE : PHASE_PROTECT;
          ticks = 0;
        end
        PHASE_PROTECT: begin
          if (ticks > period) begin
            res.commanded_rpm = pid_rpm(t.measured_rpm);
            res.duty          = duty_of(res.commanded_rpm);
            res.duty_valid    = 1'b1;
            ticks = 0;
          end
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      mode_rel = 1'b0;
      period   = 10;
      target   = 0;
      rpm_max  = 3000;
      rpm_min  = 0;
      gain_p   = 256;
      gain_i   = 0;
      gain_d   = 0;
      phase    = PHASE_INIT;
      ticks    = 0;
      err_sum  = 0;
      prev_err = 0;
      duty_expected_q.delete();
      mismatches = 0;
    end else begin
      // results first: a tick accepted now cannot have its result out yet
      if (out_valid && out_ready) begin
        if (duty_expected_q.size() == 0) begin
          report_mismatch("unexpected result, commanded_rpm", 0, out_data.commanded_rpm);
        end else begin
          want = duty_expected_q.pop_front();
          if (out_data.duty_valid !== want.duty_valid)
            report_mismatch("duty_valid", want.duty_valid, out_data.duty_valid);
          if (out_data.duty !== want.duty)
            report_mismatch("duty", want.duty, out_data.duty);
          if (out_data.commanded_rpm !== want.commanded_rpm)
            report_mismatch("commanded_rpm", want.commanded_rpm, out_data.commanded_rpm);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_MODE:          mode_rel = cfg_data[0];
          CFG_SAMPLE_PERIOD: period   = cfg_data;
          CFG_TARGET_RPM:    target   = cfg_data;
          CFG_MAX_RPM:       rpm_max  = cfg_data;
          CFG_MIN_RPM:       rpm_min  = cfg_data;
          CFG_KP:            gain_p   = cfg_data;
          CFG_KI:            gain_i   = cfg_data;
          CFG_KD:            gain_d   = cfg_data;
          default: ;
        endcase
        phase = PHASE_INIT;
        ticks = 0;
      end
      if (in_valid && in_ready)
        duty_expected_q.push_back(advance_tick(in_data));
    end
    pending = duty_expected_q.size();
  end

endmodule

/* tb/sv/sampled_pid_speed_to_duty_top_test.sv */
`timescale 1ns / 1ps

module sampled_pid_speed_to_duty_top_test;

  import spd_pkg::*;

  // Slowest legal run: ~1700 ticks, nearly all with a PID step, plus long sink
  // and source stalls and drain pauses. The limit is set above the length of
  // such a run.
  localparam longint CYCLE_LIMIT = 2_000_000;

  localparam int RANDOM_BLOCKS = 10;   // per idling pattern
  localparam int BLOCK_TICKS   = 55;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RPM_W-1:0]     cfg_data;

  int     mismatches;
  int     pending;
  int     send_idle_pct = 14;
  int     recv_idle_pct = 87;
  longint cycles = 0;

  // what the stimulus last wrote, so speeds can be aimed near the setpoint
  logic [15:0] tgt_now = 16'd0;
  logic [15:0] max_now = 16'd3000;

  sampled_pid_speed_to_duty_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sampled_pid_speed_to_duty_checker u_duty_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // sink side: stalls at random, pattern set by recv_idle_pct
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One tick transfer. Entered and left on a falling edge; valid is left
  // high so that a following tick can go out back to back.
  task automatic send_tick(input logic run_flag, input logic [15:0] speed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{run: run_flag, measured_rpm: speed};
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  // Stop sending and wait until every expected result has been taken. Each
  // tick gives exactly one result, so a short margin after that is enough.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(negedge clk);
  endtask

  // Leaves cfg_write high; end_writes lowers it after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_TARGET_RPM) tgt_now = val;
    if (idx == CFG_MAX_RPM)    max_now = val;
    @(negedge clk);
  endtask

  task automatic end_writes();
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(0, 1024));
    if (r < 85) return 16'($urandom_range(0, 65535));
    return 16'd0;
  endfunction

  // New random settings; with all_regs clear only some registers change.
  // Short sample periods dominate so that most ticks reach a PID step.
  task automatic shuffle_settings(input bit all_regs);
    logic [15:0] v;
    int          r;
    if (all_regs || $urandom_range(0, 9) < 7) begin
      v = 16'($urandom_range(0, 65535));
      v[0] = ($urandom_range(0, 99) < 15);       // upper bits are don't-care
      write_reg(CFG_MODE, v);
    end
    if (all_regs || $urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 99);
      if (r < 60)      v = 16'($urandom_range(0, 3));
      else if (r < 92) v = 16'($urandom_range(4, 20));
      else             v = 16'($urandom_range(0, 65535));
      write_reg(CFG_SAMPLE_PERIOD, v);
    end
    if (all_regs || $urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 99) < 30) v = 16'($urandom_range(0, 4000));
      else                            v = 16'($urandom_range(0, 65535));
      write_reg(CFG_TARGET_RPM, v);
    end
    if (all_regs || $urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 99) < 15) v = 16'($urandom_range(1, 300));
      else                            v = 16'($urandom_range(1, 65535));
      write_reg(CFG_MAX_RPM, v);
    end
    if (all_regs || $urandom_range(0, 9) < 7) begin
      // mostly below the upper clamp; sometimes above it for duty overflow
      if ($urandom_range(0, 99) < 75) v = 16'($urandom_range(0, max_now));
      else                            v = 16'($urandom_range(0, 65535));
      write_reg(CFG_MIN_RPM, v);
    end
    if (all_regs || $urandom_range(0, 9) < 7) write_reg(CFG_KP, pick_gain());
    if (all_regs || $urandom_range(0, 9) < 7) write_reg(CFG_KI, pick_gain());
    if (all_regs || $urandom_range(0, 9) < 7) write_reg(CFG_KD, pick_gain());
    end_writes();
  endtask

  // speed readings: near the setpoint, anywhere, or at the rails
  function automatic logic [15:0] pick_speed();
    int r, s;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      s = int'(tgt_now) + $urandom_range(0, 400) - 200;
      if (s < 0) s = 0;
      if (s > 65535) s = 65535;
      return 16'(s);
    end
    if (r < 85) return 16'($urandom_range(0, 65535));
    if (r < 93) return 16'd0;
    return 16'hFFFF;
  endfunction

  task automatic random_block(input bit all_regs);
    wait_idle();
    shuffle_settings(all_regs);
    for (int i = 0; i < BLOCK_TICKS; i++) begin
      // now and then hold off until the block has drained completely
      if ($urandom_range(0, 99) < 4) wait_idle();
      send_tick($urandom_range(0, 99) >= 4, pick_speed());
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_MODE;
    cfg_data  = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed ---
    // unit gain, no integral: stop, init, full drive, negative error, stop again
    write_reg(CFG_SAMPLE_PERIOD, 16'd0);
    write_reg(CFG_TARGET_RPM, 16'd3000);
    write_reg(CFG_KD, 16'd0);
    end_writes();
    send_tick(1'b0, 16'd0);
    send_tick(1'b1, 16'd0);
    send_tick(1'b1, 16'd0);
    send_tick(1'b1, 16'hFFFF);
    send_tick(1'b1, 16'd1500);
    send_tick(1'b0, 16'd1500);
    send_tick(1'b1, 16'd1500);
    send_tick(1'b1, 16'd1500);

    // all gains and the upper limit at the top; integral bound bites hard
    wait_idle();
    write_reg(CFG_KP, 16'hFFFF);
    write_reg(CFG_KI, 16'hFFFF);
    write_reg(CFG_KD, 16'hFFFF);
    write_reg(CFG_MAX_RPM, 16'hFFFF);
    write_reg(CFG_MIN_RPM, 16'd100);
    write_reg(CFG_TARGET_RPM, 16'hFFFF);
    end_writes();
    send_tick(1'b1, 16'd0);
    send_tick(1'b1, 16'd0);
    send_tick(1'b1, 16'hFFFF);
    send_tick(1'b1, 16'd0);
    send_tick(1'b1, 16'd32768);

    // full scale of zero: duty must read zero
    wait_idle();
    write_reg(CFG_MAX_RPM, 16'd0);
    write_reg(CFG_MIN_RPM, 16'd5);
    write_reg(CFG_KP, 16'd256);
    write_reg(CFG_KI, 16'd1);
    write_reg(CFG_KD, 16'd0);
    end_writes();
    send_tick(1'b1, 16'd0);
    send_tick(1'b1, 16'd0);
    send_tick(1'b1, 16'd0);

    // lower clamp above the upper one: duty saturates
    wait_idle();
    write_reg(CFG_MAX_RPM, 16'd10);
    write_reg(CFG_MIN_RPM, 16'd1000);
    end_writes();
    send_tick(1'b1, 16'd0);
    send_tick(1'b1, 16'd0);
    send_tick(1'b1, 16'd40000);

    // release mode: ticks give all-zero results
    wait_idle();
    write_reg(CFG_MODE, 16'd1);
    end_writes();
    send_tick(1'b1, 16'd0);
    send_tick(1'b1, 16'd0);
    send_tick(1'b0, 16'd0);
    send_tick(1'b1, 16'd0);

    // longest sample period: no step for a good while
    wait_idle();
    write_reg(CFG_MODE, 16'd0);
    write_reg(CFG_SAMPLE_PERIOD, 16'hFFFF);
    write_reg(CFG_MIN_RPM, 16'd0);
    end_writes();
    send_tick(1'b1, 16'd123);
    send_tick(1'b1, 16'd123);

    // --- random: source mostly busy / sink mostly stalled, then swapped,
    // then no idling at all ---
    for (int m = 0; m < 3; m++) begin
      send_idle_pct = (m == 0) ? 14 : (m == 1) ? 87 : 0;
      recv_idle_pct = (m == 0) ? 87 : (m == 1) ? 14 : 0;
      for (int b = 0; b < RANDOM_BLOCKS; b++)
        random_block(b == 0);
    end

    // drain, then allow one PID step worth of cycles for stray results
    wait_idle();
    repeat (120) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
